// ----- src/mrmu_pkg.sv -----
`timescale 1ns / 1ps

package mrmu_pkg;

  localparam int WORD_COUNT_DEF = 256;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 8;
  localparam int OP_W = 5;

  // Bit positions in the output flag register.
  localparam int FLAG_MO = 0;
  localparam int FLAG_DO = 1;
  localparam int FLAG_ME = 2;
  localparam int FLAG_AO = 3;

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] ADDR_DRIVE_MASK = DATA_W'(8'hFF);

  typedef enum logic [OP_W-1:0] {
    OP_STOP        = 5'd0,
    OP_SET_ADDR    = 5'd1,
    OP_ADDR_OUT    = 5'd2,
    OP_DATA_OUT_ME = 5'd3,
    OP_WR_MASKED   = 5'd4,
    OP_WR_MASKED_I = 5'd5,
    OP_WR_MASKED_D = 5'd6,
    OP_ADDR_INC    = 5'd7,
    OP_ADDR_DEC    = 5'd8,
    OP_LOAD_MASK   = 5'd9,
    OP_MASK_OUT    = 5'd10,
    OP_ME_SET      = 5'd11,
    OP_ME_CLR      = 5'd12,
    OP_DATA_OUT    = 5'd13,
    OP_WR          = 5'd14,
    OP_WR_I        = 5'd15,
    OP_WR_D        = 5'd16,
    OP_RESTORE     = 5'd17
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_REREAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic exec;
  } cmd_t;

endpackage

// ----- src/mrmu_ram.sv -----
`timescale 1ns / 1ps

module mrmu_ram #(
  parameter int WIDTH = mrmu_pkg::DATA_W,
  parameter int DEPTH = mrmu_pkg::WORD_COUNT_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/mrmu_ctrl.sv -----
`timescale 1ns / 1ps

module mrmu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output mrmu_pkg::cmd_t cmd
);

  mrmu_pkg::state_t state, state_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrmu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    busy       = !((state == mrmu_pkg::ST_IDLE) || (state == mrmu_pkg::ST_DONE));
    accept     = start && !busy;
    done       = 1'b0;
    cmd        = '0;
    cmd.load   = accept;
    state_next = state;
    unique case (state)
      mrmu_pkg::ST_IDLE: begin
        if (accept) state_next = mrmu_pkg::ST_READ;
      end
      mrmu_pkg::ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = mrmu_pkg::ST_EXEC;
      end
      mrmu_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = mrmu_pkg::ST_REREAD;
      end
      mrmu_pkg::ST_REREAD: begin
        cmd.rd_en  = 1'b1;
        state_next = mrmu_pkg::ST_DONE;
      end
      mrmu_pkg::ST_DONE: begin
        // A new command may be taken in the same cycle as the result transfer.
        done       = 1'b1;
        state_next = accept ? mrmu_pkg::ST_READ : mrmu_pkg::ST_IDLE;
      end
      default: state_next = mrmu_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- src/mrmu_datapath.sv -----
`timescale 1ns / 1ps

module mrmu_datapath #(
  parameter int WORD_COUNT = mrmu_pkg::WORD_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mrmu_pkg::cmd_t               cmd,
  input  logic [mrmu_pkg::OP_W-1:0]    op,
  input  logic [mrmu_pkg::DATA_W-1:0]  bus_data,
  output logic [mrmu_pkg::DATA_W-1:0]  drive_value,
  output logic [mrmu_pkg::DATA_W-1:0]  drive_mask
);

  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int ADDR_SPAN = 1 << mrmu_pkg::ADDR_W;

  logic [mrmu_pkg::OP_W-1:0]   op_q;
  logic [mrmu_pkg::DATA_W-1:0] bus_q;
  logic [mrmu_pkg::ADDR_W-1:0] cur_address, cur_address_next;
  logic [mrmu_pkg::ADDR_W-1:0] saved_address, saved_address_next;
  logic [mrmu_pkg::DATA_W-1:0] write_mask, write_mask_next;
  logic [3:0]                  flags, flags_next;
  logic [WORD_COUNT-1:0]       valid;
  logic                        rd_valid;
  logic [AW-1:0]               slot_lut [ADDR_SPAN];
  logic [AW-1:0]               slot;
  logic [mrmu_pkg::DATA_W-1:0] rdata, word, wdata;
  logic                        we;

  // Address to word index, worked out at elaboration for any store size.
  for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_slot
    assign slot_lut[g] = AW'(g % WORD_COUNT);
  end

  assign slot = slot_lut[cur_address];

  mrmu_ram #(
    .WIDTH(mrmu_pkg::DATA_W),
    .DEPTH(WORD_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we && cmd.exec),
    .waddr(slot),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(slot),
    .rdata(rdata)
  );

  // A word never written since reset reads as zero.
  assign word = rd_valid ? rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      bus_q <= bus_data;
    end
    if (cmd.rd_en) begin
      rd_valid <= valid[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_address   <= '0;
      saved_address <= '0;
      write_mask    <= mrmu_pkg::ALL_ONES;
      flags         <= '0;
      valid         <= '0;
    end else if (cmd.exec) begin
      cur_address   <= cur_address_next;
      saved_address <= saved_address_next;
      write_mask    <= write_mask_next;
      flags         <= flags_next;
      if (we) begin
        valid[slot] <= 1'b1;
      end
    end
  end

  always_comb begin
    cur_address_next   = cur_address;
    saved_address_next = saved_address;
    write_mask_next    = write_mask;
    flags_next         = flags;
    we                 = 1'b0;
    wdata              = bus_q;
    unique case (op_q)
      mrmu_pkg::OP_STOP: begin
        flags_next = flags & (4'b1 << mrmu_pkg::FLAG_ME);
      end
      mrmu_pkg::OP_SET_ADDR: begin
        saved_address_next = cur_address;
        cur_address_next   = bus_q[mrmu_pkg::ADDR_W-1:0];
      end
      mrmu_pkg::OP_ADDR_OUT: begin
        flags_next = (flags & (4'b1 << mrmu_pkg::FLAG_ME)) | (4'b1 << mrmu_pkg::FLAG_AO);
      end
      mrmu_pkg::OP_DATA_OUT_ME: begin
        flags_next = (4'b1 << mrmu_pkg::FLAG_ME) | (4'b1 << mrmu_pkg::FLAG_DO);
      end
      mrmu_pkg::OP_WR_MASKED: begin
        we    = 1'b1;
        wdata = (bus_q & write_mask) | (word & ~write_mask);
      end
      mrmu_pkg::OP_WR_MASKED_I: begin
        we               = 1'b1;
        wdata            = (bus_q & write_mask) | (word & ~write_mask);
        cur_address_next = cur_address + 8'd1;
      end
      mrmu_pkg::OP_WR_MASKED_D: begin
        we               = 1'b1;
        wdata            = (bus_q & write_mask) | (word & ~write_mask);
        cur_address_next = cur_address - 8'd1;
      end
      mrmu_pkg::OP_ADDR_INC: cur_address_next = cur_address + 8'd1;
      mrmu_pkg::OP_ADDR_DEC: cur_address_next = cur_address - 8'd1;
      mrmu_pkg::OP_LOAD_MASK: write_mask_next = bus_q;
      mrmu_pkg::OP_MASK_OUT: begin
        flags_next = (flags & (4'b1 << mrmu_pkg::FLAG_ME)) | (4'b1 << mrmu_pkg::FLAG_MO);
      end
      mrmu_pkg::OP_ME_SET: flags_next = flags | (4'b1 << mrmu_pkg::FLAG_ME);
      mrmu_pkg::OP_ME_CLR: flags_next = flags & ~(4'b1 << mrmu_pkg::FLAG_ME);
      mrmu_pkg::OP_DATA_OUT: flags_next = 4'b1 << mrmu_pkg::FLAG_DO;
      mrmu_pkg::OP_WR: we = 1'b1;
      mrmu_pkg::OP_WR_I: begin
        we               = 1'b1;
        cur_address_next = cur_address + 8'd1;
      end
      mrmu_pkg::OP_WR_D: begin
        we               = 1'b1;
        cur_address_next = cur_address - 8'd1;
      end
      mrmu_pkg::OP_RESTORE: cur_address_next = saved_address;
      default: ;
    endcase
  end

  // Data-out takes precedence over address-out, which takes precedence over mask-out.
  always_comb begin
    priority if (flags[mrmu_pkg::FLAG_DO]) begin
      drive_value = word;
      drive_mask  = flags[mrmu_pkg::FLAG_ME] ? write_mask : mrmu_pkg::ALL_ONES;
    end else if (flags[mrmu_pkg::FLAG_AO]) begin
      drive_value = mrmu_pkg::DATA_W'(cur_address);
      drive_mask  = mrmu_pkg::ADDR_DRIVE_MASK;
    end else if (flags[mrmu_pkg::FLAG_MO]) begin
      drive_value = write_mask;
      drive_mask  = mrmu_pkg::ALL_ONES;
    end else begin
      drive_value = '0;
      drive_mask  = '0;
    end
  end

endmodule

// ----- src/masked_register_memory_unit.sv -----
`timescale 1ns / 1ps
// The result strobe (done) follows READ, EXEC and REREAD after a command is taken; commands
// are taken only when not busy. Each command reads the store, writes it back if the operation
// writes, then reads the word at the new address, all through the one RAM with registered
// read. Reset (rst, synchronous) clears address, saved address and flags, sets the mask to
// all ones and clears the per-word valid bits, so every word reads zero; no clearing pass.
// The receiver cannot stall: each result is on the ports for the single cycle of done.

module masked_register_memory_unit #(
  parameter int WORD_COUNT = mrmu_pkg::WORD_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [mrmu_pkg::OP_W-1:0]    op,
  input  logic [mrmu_pkg::DATA_W-1:0]  bus_data,
  output logic                         done,
  output logic [mrmu_pkg::DATA_W-1:0]  drive_value,
  output logic [mrmu_pkg::DATA_W-1:0]  drive_mask
);

  mrmu_pkg::cmd_t cmd;

  mrmu_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  mrmu_datapath #(
    .WORD_COUNT(WORD_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .bus_data   (bus_data),
    .drive_value(drive_value),
    .drive_mask (drive_mask)
  );

  // Every transfer in produces its result after the READ, EXEC and REREAD states.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result strobe missing four cycles after a command transfer");

  // No result appears without a matching command taken ahead of READ, EXEC and REREAD.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching command transfer");

  // Once a command is taken the unit stays busy until its result is due.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("unit not busy after a command transfer");

endmodule
